// ----- rtl/core/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and CORDIC angle table for the quaternion to Euler
// angle block.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CordicStagesDef = 16;
  localparam int MaxStages       = 32;
  localparam int QueueDepthDef   = 4;
  localparam int DpW             = 40;   // CORDIC x/y datapath width
  localparam int ZW              = 26;   // angle accumulator, 2^-16 degree

  localparam logic [30:0] ThreshReset = 31'd1073740750;
  localparam logic signed [31:0] Q30One = 32'sd1073741824;
  localparam logic signed [ZW-1:0] Deg90Fine = ZW'(90 * 65536);
  localparam int AngLimit   = 23040;
  localparam int PitchLimit = 11520;

  // operands for the three angle units, plus branch info
  typedef struct packed {
    logic signed [DpW-1:0] roll_y;
    logic signed [DpW-1:0] roll_x;
    logic signed [DpW-1:0] pitch_y;
    logic signed [DpW-1:0] pitch_x;
    logic signed [DpW-1:0] yaw_y;
    logic signed [DpW-1:0] yaw_x;
    logic                  lock;
    logic                  pitch_neg;   // gimbal: r31 > 0
  } q2e_job_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               lock;
  } q2e_res_t;

  function automatic logic signed [ZW-1:0] atan_fine(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = ZW'(2949120);  1: t = ZW'(1740967);  2: t = ZW'(919879);
      3: t = ZW'(466945);   4: t = ZW'(234379);   5: t = ZW'(117304);
      6: t = ZW'(58666);    7: t = ZW'(29335);    8: t = ZW'(14668);
      9: t = ZW'(7334);     10: t = ZW'(3667);    11: t = ZW'(1833);
      12: t = ZW'(917);     13: t = ZW'(458);     14: t = ZW'(229);
      15: t = ZW'(115);     16: t = ZW'(57);      17: t = ZW'(29);
      18: t = ZW'(14);      19: t = ZW'(7);       20: t = ZW'(4);
      21: t = ZW'(2);       22: t = ZW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- rtl/core/q2e_front.sv -----
// ----------------------------------------------------------------------------
// q2e_front
// Accepts quaternions, forms the rotation terms, classifies the gimbal case
// and builds CORDIC operands. Pipelined, one word per cycle while en is high.
// ----------------------------------------------------------------------------
module q2e_front import q2e_pkg::*; #(
  parameter int SqrtSteps = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_data,
  input  logic [30:0]       thresh,
  output logic              out_valid,
  output q2e_job_t          out_job
);

  localparam int Lat = 4 + SqrtSteps;

  logic [Lat-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end
  assign out_valid = vld[Lat-1];

  // stage 1: products
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= $signed(in_data[15:0])  * $signed(in_data[15:0]);
      p_xx <= $signed(in_data[31:16]) * $signed(in_data[31:16]);
      p_yy <= $signed(in_data[47:32]) * $signed(in_data[47:32]);
      p_zz <= $signed(in_data[63:48]) * $signed(in_data[63:48]);
      p_xy <= $signed(in_data[31:16]) * $signed(in_data[47:32]);
      p_wz <= $signed(in_data[15:0])  * $signed(in_data[63:48]);
      p_xz <= $signed(in_data[31:16]) * $signed(in_data[63:48]);
      p_wy <= $signed(in_data[15:0])  * $signed(in_data[47:32]);
      p_yz <= $signed(in_data[47:32]) * $signed(in_data[63:48]);
      p_wx <= $signed(in_data[15:0])  * $signed(in_data[31:16]);
    end
  end

  // stage 2: matrix terms
  logic signed [31:0] r11, r21, r31, r32, r33, r12, r13;
  always_ff @(posedge clk) begin
    if (en) begin
      r11 <= sat32(35'(p_ww) + 35'(p_xx) - 35'(p_yy) - 35'(p_zz));
      r33 <= sat32(35'(p_ww) - 35'(p_xx) - 35'(p_yy) + 35'(p_zz));
      r21 <= sat32((35'(p_xy) + 35'(p_wz)) <<< 1);
      r31 <= sat32((35'(p_xz) - 35'(p_wy)) <<< 1);
      r32 <= sat32((35'(p_yz) + 35'(p_wx)) <<< 1);
      r12 <= sat32((35'(p_xy) - 35'(p_wz)) <<< 1);
      r13 <= sat32((35'(p_xz) + 35'(p_wy)) <<< 1);
    end
  end

  // stage 3: classify, gimbal denominator, asin argument
  logic [31:0] a31;
  logic signed [32:0] ns;
  logic signed [32:0] s_cl;
  assign a31 = r31[31] ? 32'(-33'(r31)) : r31;
  assign ns  = -33'(r31);
  assign s_cl = (ns > 33'(Q30One)) ? 33'(Q30One) :
                (ns < -33'(Q30One)) ? -33'(Q30One) : ns;

  logic signed [63:0] g_prod;
  assign g_prod = 64'(r31) * 64'(r13);

  logic               s3_lock, s3_pneg;
  logic signed [32:0] s3_s, s3_den, s3_ny12;
  logic signed [31:0] s3_r11, s3_r21, s3_r32, s3_r33;
  logic [61:0]        s3_rad;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_lock <= a31 > {1'b0, thresh};
      s3_pneg <= r31 > 0;
      s3_s    <= s_cl;
      s3_den  <= 33'((-65'(g_prod)) >>> 30);
      s3_ny12 <= -33'(r12);
      s3_r11 <= r11; s3_r21 <= r21; s3_r32 <= r32; s3_r33 <= r33;
      s3_rad  <= 62'(64'(1) << 60) - 62'(s_cl * s_cl);
    end
  end

  // square root pipeline, one result bit a stage
  typedef struct packed {
    logic [61:0]        rem;
    logic [30:0]        root;
    logic               lock, pneg;
    logic signed [32:0] s, den, ny12;
    logic signed [31:0] r11, r21, r32, r33;
  } sq_t;

  sq_t sq [SqrtSteps+1];
  always_comb begin
    sq[0].rem = s3_rad; sq[0].root = '0; sq[0].lock = s3_lock; sq[0].pneg = s3_pneg;
    sq[0].s = s3_s; sq[0].den = s3_den; sq[0].ny12 = s3_ny12;
    sq[0].r11 = s3_r11; sq[0].r21 = s3_r21; sq[0].r32 = s3_r32; sq[0].r33 = s3_r33;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sq
    localparam int B = SqrtSteps - 1 - k;
    logic [62:0] trial;
    logic [62:0] rm;
    sq_t nx;
    assign rm    = {1'b0, sq[k].rem};
    // (root + 2^B)^2 - root^2
    assign trial = (63'(sq[k].root) << (B + 1)) + (63'(1) << (2 * B));
    always_comb begin
      nx = sq[k];
      if (rm >= trial) begin
        nx.rem  = 62'(rm - trial);
        nx.root = sq[k].root | (31'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (en) sq[k+1] <= nx;
    end
  end

  sq_t f;
  assign f = sq[SqrtSteps];
  always_ff @(posedge clk) begin
    if (en) begin
      out_job.lock      <= f.lock;
      out_job.pitch_neg <= f.pneg;
      out_job.roll_y    <= DpW'(f.r32);
      out_job.roll_x    <= DpW'(f.r33);
      out_job.pitch_y   <= DpW'(f.s);
      out_job.pitch_x   <= DpW'({1'b0, f.root});
      out_job.yaw_y     <= f.lock ? DpW'(f.ny12) : DpW'(f.r21);
      out_job.yaw_x     <= f.lock ? DpW'(f.den)  : DpW'(f.r11);
    end
  end

endmodule

// ----- rtl/core/q2e_fifo.sv -----
// ----------------------------------------------------------------------------
// q2e_fifo
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module q2e_fifo import q2e_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             empty,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr_en) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end
  assign rd_data = mem[rp];
  assign empty   = (count == '0);

endmodule

// ----- rtl/core/q2e_cordic.sv -----
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC, atan2 in 1/128 degree clamped to +-180.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; #(
  parameter int Stages = CordicStagesDef
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [DpW-1:0] y_in,
  input  logic signed [DpW-1:0] x_in,
  output logic signed [15:0]    angle
);

  localparam int N = (Stages < MaxStages) ? Stages : MaxStages;

  logic signed [DpW-1:0] xs [N+1];
  logic signed [DpW-1:0] ys [N+1];
  logic signed [ZW-1:0]  zs [N+1];
  logic                  zero [N+1];

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == 0) && (y_in == 0);
      if (x_in < 0 && y_in >= 0) begin
        xs[0] <= y_in; ys[0] <= -x_in; zs[0] <= Deg90Fine;
      end else if (x_in < 0) begin
        xs[0] <= -y_in; ys[0] <= x_in; zs[0] <= -Deg90Fine;
      end else begin
        xs[0] <= x_in; ys[0] <= y_in; zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_fine(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_fine(i);
        end
      end
    end
  end

  logic signed [ZW-1:0] rz;
  assign rz = (zs[N] + ZW'(256)) >>> 9;
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[N])                    angle <= '0;
      else if (rz > ZW'(AngLimit))    angle <= 16'(AngLimit);
      else if (rz < -ZW'(AngLimit))   angle <= -16'(AngLimit);
      else                            angle <= rz[15:0];
    end
  end

endmodule

// ----- rtl/core/q2e_back.sv -----
// ----------------------------------------------------------------------------
// q2e_back
// Three CORDIC lanes with combinational output selection; stalls as one pipe.
// ----------------------------------------------------------------------------
module q2e_back import q2e_pkg::*; #(
  parameter int CordicStages = CordicStagesDef
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  q2e_job_t in_job,
  output logic     out_valid,
  output q2e_res_t out_res
);

  localparam int N   = (CordicStages < MaxStages) ? CordicStages : MaxStages;
  localparam int Lat = N + 2;

  logic [Lat-1:0] vld;
  logic [Lat-1:0] lk;
  logic [Lat-1:0] pn;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lk <= {lk[Lat-2:0], in_job.lock};
      pn <= {pn[Lat-2:0], in_job.pitch_neg};
    end
  end

  logic signed [15:0] a_roll, a_pitch, a_yaw;
  q2e_cordic #(.Stages(CordicStages)) u_roll (
    .clk(clk), .en(en), .y_in(in_job.roll_y), .x_in(in_job.roll_x), .angle(a_roll));
  q2e_cordic #(.Stages(CordicStages)) u_pitch (
    .clk(clk), .en(en), .y_in(in_job.pitch_y), .x_in(in_job.pitch_x), .angle(a_pitch));
  q2e_cordic #(.Stages(CordicStages)) u_yaw (
    .clk(clk), .en(en), .y_in(in_job.yaw_y), .x_in(in_job.yaw_x), .angle(a_yaw));

  assign out_valid = vld[Lat-1];
  always_comb begin
    out_res.lock = lk[Lat-1];
    out_res.yaw  = a_yaw;
    if (lk[Lat-1]) begin
      out_res.roll  = '0;
      out_res.pitch = pn[Lat-1] ? -15'(PitchLimit) : 15'(PitchLimit);
    end else begin
      out_res.roll = a_roll;
      if (a_pitch > 16'(PitchLimit))       out_res.pitch = 15'(PitchLimit);
      else if (a_pitch < -16'(PitchLimit)) out_res.pitch = -15'(PitchLimit);
      else                                 out_res.pitch = a_pitch[14:0];
    end
  end

endmodule

// ----- rtl/core/quaternion_to_euler_angles.sv -----
// Stages: 35 front stages, 1 queue, CORDIC_STAGES + 2 back stages, output reg.
// Throughput: one quaternion per cycle while not stalled; front pipe is set by the
// 31-step square root, back pipe by the CORDIC stage count.
// Front stalls only while its last word waits on a full queue; back stalls on tready.
// rst (synchronous) empties both pipes and the queue and restores the threshold.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion to ZYX roll, pitch and yaw, with gimbal-lock detection.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tuser    // gimbal_lock
);

  localparam int QDepth   = QueueDepthDef;
  localparam int CW       = $clog2(QDepth + 1);

  logic [30:0] thresh;
  always_ff @(posedge clk) begin
    if (rst)         thresh <= ThreshReset;
    else if (cfg_we) thresh <= cfg_wdata;
  end

  // front: holds as one pipe while its last word waits on a full queue
  logic [CW-1:0] q_count;
  logic          f_valid, f_en;
  q2e_job_t      f_job;

  assign f_en          = !(f_valid && (q_count == CW'(QDepth)));
  assign s_axis_tready = f_en;

  q2e_front u_front (
    .clk(clk), .rst(rst), .en(f_en), .in_valid(s_axis_tvalid && s_axis_tready),
    .in_data(s_axis_tdata), .thresh(thresh), .out_valid(f_valid), .out_job(f_job));

  logic     q_empty, q_rd;
  q2e_job_t q_job;
  q2e_fifo #(.Width($bits(q2e_job_t)), .Depth(QDepth)) u_q (
    .clk(clk), .rst(rst), .wr_en(f_valid && f_en), .wr_data(f_job),
    .rd_en(q_rd), .rd_data(q_job), .empty(q_empty), .count(q_count));

  // back pipe advances when it holds no finished word or its output slot is free or being taken
  logic     b_en, b_valid, out_free;
  q2e_res_t b_res;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign b_en     = !b_valid || out_free;
  assign q_rd     = b_en && !q_empty;

  q2e_back #(.CordicStages(CORDIC_STAGES)) u_back (
    .clk(clk), .rst(rst), .en(b_en), .in_valid(q_rd), .in_job(q_job),
    .out_valid(b_valid), .out_res(b_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= b_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (out_free && b_valid) begin
      m_axis_tdata <= {1'b0, b_res.yaw, b_res.pitch, b_res.roll};
      m_axis_tuser <= b_res.lock;
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_count <= CW'(QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("roll nonzero in gimbal case");

endmodule
